// ----- rtl/efrwa_pkg.sv -----
// Shared types, constants and helpers of the escaped frame receiver.
`timescale 1ns / 1ps

package efrwa_pkg;

   localparam logic [7:0] START_CODE  = 8'h7E;
   localparam logic [7:0] ESCAPE_CODE = 8'h7D;
   localparam logic [7:0] XON_CODE    = 8'h11;
   localparam logic [7:0] XOFF_CODE   = 8'h13;
   localparam logic [7:0] LF_CODE     = 8'h0A;
   localparam logic [7:0] CR_CODE     = 8'h0D;
   localparam logic [7:0] ESC_XOR     = 8'h20;
   localparam logic [7:0] ACK_LENGTH  = 8'h01;
   localparam logic [7:0] SUM_GOOD    = 8'hFF;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_DATA_TYPE = 3'd0;
   localparam logic [2:0] REG_ACK_TYPE  = 3'd1;
   localparam logic [2:0] REG_ACK_OK    = 3'd2;
   localparam logic [2:0] REG_ACK_FAIL  = 3'd3;
   localparam logic [2:0] REG_BREAK     = 3'd4;
   localparam logic [2:0] REG_TIMEOUT   = 3'd5;

   // Input modes.
   localparam logic [1:0] MODE_BYTE = 2'd0;
   localparam logic [1:0] MODE_TICK = 2'd1;
   localparam logic [1:0] MODE_ARM  = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_STATUS  = 2'd1;
   localparam logic [1:0] KIND_ACK     = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_SUM = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;
   localparam logic [1:0] ST_BREAK   = 2'd3;

   // Steps of an ack frame in the back end.
   typedef enum logic [5:0] {
      STEP_START  = 6'b000001,
      STEP_LEN    = 6'b000010,
      STEP_TYPE   = 6'b000100,
      STEP_CODE   = 6'b001000,
      STEP_CHECK  = 6'b010000,
      STEP_STATUS = 6'b100000
   } step_type;

   typedef enum logic [5:0] {
      PH_IDLE  = 6'b000001,
      PH_HUNT  = 6'b000010,
      PH_LEN   = 6'b000100,
      PH_TYPE  = 6'b001000,
      PH_PAY   = 6'b010000,
      PH_CHECK = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      JOB_PAYLOAD = 2'd0,
      JOB_STATUS  = 2'd1,
      JOB_ACK     = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   data;
      logic [7:0]   index;
      logic [1:0]   status;
      logic         brk;
      logic [7:0]   code;
   } job_type;

   typedef struct packed {
      logic [7:0]  data_type_code;
      logic [7:0]  ack_type_code;
      logic [7:0]  ack_ok_code;
      logic [7:0]  ack_fail_code;
      logic [7:0]  break_code;
      logic [15:0] timeout_ms;
   } cfg_type;

   function automatic logic needs_escape(input logic [7:0] b);
      return (b == START_CODE) || (b == ESCAPE_CODE) || (b == XON_CODE) ||
             (b == XOFF_CODE) || (b == LF_CODE) || (b == CR_CODE);
   endfunction

endpackage

// ----- rtl/efrwa_front.sv -----
// Front end: frame parser that turns line bytes, ticks and arm commands into jobs.
`timescale 1ns / 1ps

module efrwa_front (
   input  logic              clock,
   input  logic              reset,
   input  efrwa_pkg::cfg_type cfg,
   input  logic              accept,
   input  logic [1:0]        mode,
   input  logic [7:0]        rx_byte,
   input  logic [7:0]        expected_type,
   output logic              push,
   output efrwa_pkg::job_type job
);

   efrwa_pkg::phase_type phase_ff, phase_in;
   logic        esc_ff, esc_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  ackv_ff, ackv_in;
   logic        brk_ff, brk_in;
   logic [15:0] ticks_ff, ticks_in;
   logic [7:0]  wanted_ff, wanted_in;

   logic [7:0]  b;
   logic [7:0]  sum_new;
   logic [15:0] ticks_inc;
   logic [15:0] limit;
   logic        is_data;

   assign b         = esc_ff ? (rx_byte ^ efrwa_pkg::ESC_XOR) : rx_byte;
   assign sum_new   = sum_ff + b;
   assign ticks_inc = (ticks_ff == 16'hFFFF) ? ticks_ff : ticks_ff + 16'd1;
   assign limit     = (cfg.timeout_ms == 16'd0) ? 16'd1 : cfg.timeout_ms;
   assign is_data   = (type_ff == cfg.data_type_code);

   always_comb begin
      phase_in  = phase_ff;
      esc_in    = esc_ff;
      len_in    = len_ff;
      pos_in    = pos_ff;
      type_in   = type_ff;
      sum_in    = sum_ff;
      ackv_in   = ackv_ff;
      brk_in    = brk_ff;
      ticks_in  = ticks_ff;
      wanted_in = wanted_ff;
      push      = 1'b0;
      job       = '{kind: efrwa_pkg::JOB_STATUS, data: 8'd0, index: 8'd0,
                    status: efrwa_pkg::ST_OK, brk: 1'b0, code: 8'd0};

      if (accept) begin
         if (mode == efrwa_pkg::MODE_ARM) begin
            wanted_in = expected_type;
            phase_in  = efrwa_pkg::PH_HUNT;
            esc_in    = 1'b0;
            pos_in    = 8'd0;
            ticks_in  = 16'd0;
         end else if (phase_ff != efrwa_pkg::PH_IDLE) begin
            if (mode == efrwa_pkg::MODE_TICK) begin
               if (ticks_inc >= limit) begin
                  phase_in   = efrwa_pkg::PH_IDLE;
                  esc_in     = 1'b0;
                  ticks_in   = 16'd0;
                  push       = 1'b1;
                  job.status = efrwa_pkg::ST_TIMEOUT;
                  job.brk    = brk_ff;
               end else begin
                  ticks_in = ticks_inc;
               end
            end else if (mode == efrwa_pkg::MODE_BYTE) begin
               ticks_in = 16'd0;
               if (phase_ff == efrwa_pkg::PH_HUNT) begin
                  if (rx_byte == efrwa_pkg::START_CODE) begin
                     phase_in = efrwa_pkg::PH_LEN;
                  end
               end else if (!esc_ff && rx_byte == efrwa_pkg::ESCAPE_CODE) begin
                  esc_in = 1'b1;
               end else begin
                  esc_in = 1'b0;
                  case (phase_ff)
                     efrwa_pkg::PH_LEN: begin
                        len_in   = b;
                        phase_in = efrwa_pkg::PH_TYPE;
                     end
                     efrwa_pkg::PH_TYPE: begin
                        type_in = b;
                        if (b != wanted_ff) begin
                           phase_in = efrwa_pkg::PH_HUNT;
                        end else begin
                           sum_in   = b;
                           pos_in   = 8'd0;
                           phase_in = (len_ff != 8'd0) ? efrwa_pkg::PH_PAY
                                                       : efrwa_pkg::PH_CHECK;
                        end
                     end
                     efrwa_pkg::PH_PAY: begin
                        sum_in = sum_new;
                        if (is_data) begin
                           push      = 1'b1;
                           job.kind  = efrwa_pkg::JOB_PAYLOAD;
                           job.data  = b;
                           job.index = pos_ff;
                        end else begin
                           ackv_in = b;
                        end
                        pos_in = pos_ff + 8'd1;
                        if (pos_ff + 8'd1 == len_ff) begin
                           phase_in = efrwa_pkg::PH_CHECK;
                        end
                     end
                     efrwa_pkg::PH_CHECK: begin
                        sum_in   = sum_new;
                        phase_in = efrwa_pkg::PH_IDLE;
                        push     = 1'b1;
                        if (type_ff == cfg.ack_type_code && ackv_ff == cfg.break_code) begin
                           brk_in     = 1'b1;
                           job.status = efrwa_pkg::ST_BREAK;
                           job.brk    = 1'b1;
                        end else begin
                           job.status = (sum_new == efrwa_pkg::SUM_GOOD) ?
                                        efrwa_pkg::ST_OK : efrwa_pkg::ST_BAD_SUM;
                           if (is_data) begin
                              brk_in   = 1'b0;
                              job.kind = efrwa_pkg::JOB_ACK;
                              job.code = (sum_new == efrwa_pkg::SUM_GOOD) ?
                                         cfg.ack_ok_code : cfg.ack_fail_code;
                              job.brk  = 1'b0;
                           end else begin
                              job.brk = brk_ff;
                           end
                        end
                     end
                     default: begin
                        phase_in = efrwa_pkg::PH_IDLE;
                     end
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= efrwa_pkg::PH_IDLE;
         esc_ff    <= 1'b0;
         len_ff    <= 8'd0;
         pos_ff    <= 8'd0;
         type_ff   <= 8'd0;
         sum_ff    <= 8'd0;
         ackv_ff   <= 8'd0;
         brk_ff    <= 1'b0;
         ticks_ff  <= 16'd0;
         wanted_ff <= 8'd0;
      end else begin
         phase_ff  <= phase_in;
         esc_ff    <= esc_in;
         len_ff    <= len_in;
         pos_ff    <= pos_in;
         type_ff   <= type_in;
         sum_ff    <= sum_in;
         ackv_ff   <= ackv_in;
         brk_ff    <= brk_in;
         ticks_ff  <= ticks_in;
         wanted_ff <= wanted_in;
      end
   end

endmodule

// ----- rtl/efrwa_queue.sv -----
// Short job queue between the parser and the result sequencer.
`timescale 1ns / 1ps

module efrwa_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  efrwa_pkg::job_type push_job,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output efrwa_pkg::job_type head_job
);

   efrwa_pkg::job_type              slot_ff [efrwa_pkg::QDEPTH];
   logic [efrwa_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [efrwa_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [efrwa_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign full       = (count_ff == efrwa_pkg::QCNT_W'(efrwa_pkg::QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == efrwa_pkg::QPTR_W'(efrwa_pkg::QDEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == efrwa_pkg::QPTR_W'(efrwa_pkg::QDEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/efrwa_back.sv -----
// Back end: expands queued jobs into result transfers, including escaped ack frames.
`timescale 1ns / 1ps

module efrwa_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         ack_type_code,
   input  logic               head_valid,
   input  efrwa_pkg::job_type head_job,
   output logic               pop,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [1:0]         rsp_out_kind,
   output logic [7:0]         rsp_out_byte,
   output logic [7:0]         rsp_byte_index,
   output logic [1:0]         rsp_status,
   output logic               rsp_break_flag,
   output logic               rsp_last
);

   logic       valid_ff, valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic [7:0] index_ff, index_in;
   logic [1:0] status_ff, status_in;
   logic       brk_ff, brk_in;
   logic       last_ff, last_in;
   efrwa_pkg::step_type step_ff, step_in;
   efrwa_pkg::step_type next_step;
   logic       half_ff, half_in;

   logic       load;
   logic [7:0] line_byte;

   assign load = head_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      case (step_ff)
         efrwa_pkg::STEP_LEN:   line_byte = efrwa_pkg::ACK_LENGTH;
         efrwa_pkg::STEP_TYPE:  line_byte = ack_type_code;
         efrwa_pkg::STEP_CODE:  line_byte = head_job.code;
         efrwa_pkg::STEP_CHECK: line_byte = ~(head_job.code + ack_type_code);
         default:               line_byte = efrwa_pkg::START_CODE;
      endcase
   end

   always_comb begin
      case (step_ff)
         efrwa_pkg::STEP_START: next_step = efrwa_pkg::STEP_LEN;
         efrwa_pkg::STEP_LEN:   next_step = efrwa_pkg::STEP_TYPE;
         efrwa_pkg::STEP_TYPE:  next_step = efrwa_pkg::STEP_CODE;
         efrwa_pkg::STEP_CODE:  next_step = efrwa_pkg::STEP_CHECK;
         efrwa_pkg::STEP_CHECK: next_step = efrwa_pkg::STEP_STATUS;
         default:               next_step = efrwa_pkg::STEP_START;
      endcase
   end

   always_comb begin
      valid_in  = valid_ff && rsp_stall;
      kind_in   = kind_ff;
      byte_in   = byte_ff;
      index_in  = index_ff;
      status_in = status_ff;
      brk_in    = brk_ff;
      last_in   = last_ff;
      step_in   = step_ff;
      half_in   = half_ff;
      pop       = 1'b0;

      if (load) begin
         valid_in  = 1'b1;
         byte_in   = 8'd0;
         index_in  = 8'd0;
         status_in = efrwa_pkg::ST_OK;
         brk_in    = 1'b0;
         last_in   = 1'b0;
         case (head_job.kind)
            efrwa_pkg::JOB_PAYLOAD: begin
               kind_in  = efrwa_pkg::KIND_PAYLOAD;
               byte_in  = head_job.data;
               index_in = head_job.index;
               last_in  = 1'b1;
               pop      = 1'b1;
            end
            efrwa_pkg::JOB_ACK: begin
               if (step_ff == efrwa_pkg::STEP_STATUS) begin
                  kind_in   = efrwa_pkg::KIND_STATUS;
                  status_in = head_job.status;
                  brk_in    = head_job.brk;
                  last_in   = 1'b1;
                  step_in   = efrwa_pkg::STEP_START;
                  pop       = 1'b1;
               end else if (step_ff == efrwa_pkg::STEP_START) begin
                  kind_in = efrwa_pkg::KIND_ACK;
                  byte_in = efrwa_pkg::START_CODE;
                  step_in = efrwa_pkg::STEP_LEN;
               end else if (!half_ff && efrwa_pkg::needs_escape(line_byte)) begin
                  // First half of an escaped pair; the step repeats for the XORed byte.
                  kind_in = efrwa_pkg::KIND_ACK;
                  byte_in = efrwa_pkg::ESCAPE_CODE;
                  half_in = 1'b1;
               end else begin
                  kind_in = efrwa_pkg::KIND_ACK;
                  byte_in = half_ff ? (line_byte ^ efrwa_pkg::ESC_XOR) : line_byte;
                  half_in = 1'b0;
                  step_in = next_step;
               end
            end
            default: begin
               kind_in   = efrwa_pkg::KIND_STATUS;
               status_in = head_job.status;
               brk_in    = head_job.brk;
               last_in   = 1'b1;
               pop       = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= efrwa_pkg::STEP_START;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      byte_ff   <= byte_in;
      index_ff  <= index_in;
      status_ff <= status_in;
      brk_ff    <= brk_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_kind   = kind_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_byte_index = index_ff;
   assign rsp_status     = status_ff;
   assign rsp_break_flag = brk_ff;
   assign rsp_last       = last_ff;

endmodule

// ----- rtl/escaped_frame_receiver_with_ack_core.sv -----
// Top level of the escaped frame receiver: register file, parser, job queue, sequencer.
//
// Usage: the req_ channel carries one item per transfer: an arm command with the
// wanted frame type, a received line byte, or a millisecond tick. The rsp_
// channel returns payload bytes with their index, frame status, and the bytes of
// an escaped ack frame to transmit, with rsp_last on the final result of an item.
// The first result of an item passes through the job queue and then the result
// register before it is on the rsp_ ports.
// Throughput: one item per cycle while results can drain; a finished data frame
// expands into up to eight ack byte transfers plus a status transfer, one per
// cycle while rsp_stall is low, produced by the result sequencer from a
// two-entry job queue. req_stall rises only when that job queue is full.
// Reset clears the parser to idle, empties the queue and loads the register
// defaults; the block must be armed before bytes are parsed.
// When the receiver holds rsp_stall, the result register keeps its transfer and
// the parser goes on taking items until the queue fills.
// Configuration registers sit at byte offsets 4*i on the csr_ port.
`timescale 1ns / 1ps

module escaped_frame_receiver_with_ack_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_mode,
   input  logic [7:0]                       req_rx_byte,
   input  logic [7:0]                       req_expected_type,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_out_kind,
   output logic [7:0]                       rsp_out_byte,
   output logic [7:0]                       rsp_byte_index,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_break_flag,
   output logic                             rsp_last,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [efrwa_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [efrwa_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [efrwa_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);

   efrwa_pkg::cfg_type cfg_ff, cfg_in;
   efrwa_pkg::job_type push_job;
   efrwa_pkg::job_type head_job;
   logic               csr_write;
   logic [2:0]         reg_index;
   logic               accept;
   logic               push;
   logic               pop;
   logic               full;
   logic               head_valid;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index)
            efrwa_pkg::REG_DATA_TYPE: cfg_in.data_type_code = csr_pwdata[7:0];
            efrwa_pkg::REG_ACK_TYPE:  cfg_in.ack_type_code  = csr_pwdata[7:0];
            efrwa_pkg::REG_ACK_OK:    cfg_in.ack_ok_code    = csr_pwdata[7:0];
            efrwa_pkg::REG_ACK_FAIL:  cfg_in.ack_fail_code  = csr_pwdata[7:0];
            efrwa_pkg::REG_BREAK:     cfg_in.break_code     = csr_pwdata[7:0];
            efrwa_pkg::REG_TIMEOUT:   cfg_in.timeout_ms     = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         efrwa_pkg::REG_DATA_TYPE: csr_prdata = {24'd0, cfg_ff.data_type_code};
         efrwa_pkg::REG_ACK_TYPE:  csr_prdata = {24'd0, cfg_ff.ack_type_code};
         efrwa_pkg::REG_ACK_OK:    csr_prdata = {24'd0, cfg_ff.ack_ok_code};
         efrwa_pkg::REG_ACK_FAIL:  csr_prdata = {24'd0, cfg_ff.ack_fail_code};
         efrwa_pkg::REG_BREAK:     csr_prdata = {24'd0, cfg_ff.break_code};
         efrwa_pkg::REG_TIMEOUT:   csr_prdata = {16'd0, cfg_ff.timeout_ms};
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{data_type_code: 8'd1, ack_type_code: 8'd2, ack_ok_code: 8'd0,
                     ack_fail_code: 8'd1, break_code: 8'd3, timeout_ms: 16'd1000};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = full;
   assign accept    = req_valid && !full;

   efrwa_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .accept        (accept),
      .mode          (req_mode),
      .rx_byte       (req_rx_byte),
      .expected_type (req_expected_type),
      .push          (push),
      .job           (push_job)
   );

   efrwa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   efrwa_back u_back (
      .clock          (clock),
      .reset          (reset),
      .ack_type_code  (cfg_ff.ack_type_code),
      .head_valid     (head_valid),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_status     (rsp_status),
      .rsp_break_flag (rsp_break_flag),
      .rsp_last       (rsp_last)
   );

endmodule
